[sv/irm_pkg.sv]
// irm_pkg: shared constants and types for the interval range map table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irm_pkg;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_WIDTH_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 8;
    localparam int COUNT_OUT_W     = 7;

    // Register byte addresses.
    localparam logic [2:0] ADDR_DEFAULT_VALUE = 3'd0;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ASSIGN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_CP_RD,
        ST_CP_EV,
        ST_INS_B,
        ST_INS_E,
        ST_FINISH
    } irm_state_t;
endpackage
`default_nettype wire

[sv/irm_ram.sv]
// irm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/interval_range_map_table.sv]
// interval_range_map_table: top level, sequencer and two table banks; uses irm_pkg, irm_ram.
// Lookup: one scan over the entries at or below the key. An empty assign goes straight to the result.
// Assign: one scan for the values before begin and at end, then a merge pass into the
// spare bank, each entry read from RAM and then compared. One beat in flight; a stalled
// result holds the sequencer. Reset clears count, active bank, default and handshake state only.
`timescale 1ns / 1ps
`default_nettype none
module interval_range_map_table #(
    parameter int MAX_ENTRIES = irm_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_WIDTH   = irm_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = irm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic signed [KEY_WIDTH-1:0]   range_begin,
    input  wire logic signed [KEY_WIDTH-1:0]   range_end,
    input  wire logic [VALUE_WIDTH-1:0]        new_value,
    input  wire logic signed [KEY_WIDTH-1:0]   probe_key,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [VALUE_WIDTH-1:0]             found_value,
    output logic [irm_pkg::COUNT_OUT_W-1:0]    entry_count,
    output logic                               status,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = $clog2(MAX_ENTRIES + 3);
    localparam int OW = irm_pkg::COUNT_OUT_W;
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;
    localparam logic [KEY_WIDTH-1:0] SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [VALUE_WIDTH-1:0] default_reg;
    logic                   cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == irm_pkg::ADDR_DEFAULT_VALUE[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= '0;
        end
        else if (cfg_wr)
        begin
            default_reg <= pwdata[VALUE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == irm_pkg::ADDR_DEFAULT_VALUE[2])
        begin
            prdata = 32'(default_reg);
        end
    end

    // ---------------- sequencer state ----------------
    irm_pkg::irm_state_t state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   bank_reg, bank_next;    // active bank
    logic [CW-1:0]          idx_reg, idx_next;      // read index
    logic [NW-1:0]          n_reg, n_next;          // merge write count
    logic                   hi_reg, hi_next;        // merge past begin
    logic                   type_reg;
    // request payload, keys in order code (sign bit flipped)
    logic [KEY_WIDTH-1:0]   b_reg, e_reg, p_reg;
    logic [VALUE_WIDTH-1:0] v_reg;
    logic [VALUE_WIDTH-1:0] vb_reg, vb_next;        // value before begin
    logic [VALUE_WIDTH-1:0] ve_reg, ve_next;        // value at end / lookup result
    logic                   ld_req;

    // result register
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] found_reg;
    logic [CW-1:0]          cnt_out_reg;
    logic                   status_reg;
    logic                   out_load;
    logic [VALUE_WIDTH-1:0] found_next;
    logic [CW-1:0]          cnt_out_next;
    logic                   status_next;

    // ---------------- table banks ----------------
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata0, rdata1, rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;

    irm_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_bank0 (
        .clk(clk), .we(we && bank_reg), .waddr(waddr), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rdata0)
    );
    irm_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_bank1 (
        .clk(clk), .we(we && !bank_reg), .waddr(waddr), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rdata1)
    );
    assign rdata  = bank_reg ? rdata1 : rdata0;
    assign rd_key = rdata[EW-1:VALUE_WIDTH];
    assign rd_val = rdata[VALUE_WIDTH-1:0];
    assign waddr  = n_reg[AW-1:0];

    assign in_stall = (state_reg != irm_pkg::ST_IDLE);
    assign ld_req   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irm_pkg::ST_IDLE;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        hi_reg  <= hi_next;
        vb_reg  <= vb_next;
        ve_reg  <= ve_next;
        if (ld_req)
        begin
            type_reg <= req_type;
            b_reg    <= range_begin ^ SIGN;
            e_reg    <= range_end ^ SIGN;
            p_reg    <= probe_key ^ SIGN;
            v_reg    <= new_value;
        end
        if (out_load)
        begin
            found_reg   <= found_next;
            cnt_out_reg <= cnt_out_next;
            status_reg  <= status_next;
        end
    end

    // Next state; each evaluate step compares the read key against the request bounds.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        bank_next    = bank_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        hi_next      = hi_reg;
        vb_next      = vb_reg;
        ve_next      = ve_reg;
        we           = 1'b0;
        wdata        = {rd_key, rd_val};
        out_load     = 1'b0;
        found_next   = '0;
        cnt_out_next = count_reg;
        status_next  = 1'b0;

        unique case (state_reg)
            irm_pkg::ST_IDLE:
            begin
                idx_next = '0;
                vb_next  = default_reg;
                ve_next  = default_reg;
                if (ld_req)
                begin
                    // empty range: nothing to do
                    if (req_type == irm_pkg::REQ_ASSIGN &&
                        !((range_begin ^ SIGN) < (range_end ^ SIGN)))
                    begin
                        state_next = irm_pkg::ST_FINISH;
                        hi_next    = 1'b0;
                        n_next     = NW'(count_reg);
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_SCAN_RD;
                    end
                end
            end
            irm_pkg::ST_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = irm_pkg::ST_SCAN_EV;
                end
                else if (type_reg == irm_pkg::REQ_LOOKUP)
                begin
                    state_next = irm_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = irm_pkg::ST_CP_RD;
                    idx_next   = '0;
                    n_next     = '0;
                    hi_next    = 1'b0;
                end
            end
            irm_pkg::ST_SCAN_EV:
            begin
                if (type_reg == irm_pkg::REQ_LOOKUP)
                begin
                    if (rd_key <= p_reg)
                    begin
                        ve_next    = rd_val;
                        idx_next   = idx_reg + 1'b1;
                        state_next = irm_pkg::ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_FINISH;
                    end
                end
                else if (rd_key <= e_reg)
                begin
                    if (rd_key < b_reg)
                    begin
                        vb_next = rd_val;
                    end
                    ve_next    = rd_val;
                    idx_next   = idx_reg + 1'b1;
                    state_next = irm_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = irm_pkg::ST_CP_RD;
                    idx_next   = '0;
                    n_next     = '0;
                    hi_next    = 1'b0;
                end
            end
            irm_pkg::ST_CP_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = irm_pkg::ST_CP_EV;
                end
                else if (!hi_reg)
                begin
                    state_next = irm_pkg::ST_INS_B;
                end
                else
                begin
                    state_next = irm_pkg::ST_FINISH;
                end
            end
            irm_pkg::ST_CP_EV:
            begin
                state_next = irm_pkg::ST_CP_RD;
                if (!hi_reg)
                begin
                    if (rd_key < b_reg)
                    begin
                        we       = (n_reg < NW'(MAX_ENTRIES));
                        n_next   = n_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_INS_B;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rd_key > e_reg)
                    begin
                        we     = (n_reg < NW'(MAX_ENTRIES));
                        n_next = n_reg + 1'b1;
                    end
                end
            end
            irm_pkg::ST_INS_B:
            begin
                state_next = irm_pkg::ST_INS_E;
                wdata      = {b_reg, v_reg};
                if (v_reg != vb_reg)
                begin
                    we     = (n_reg < NW'(MAX_ENTRIES));
                    n_next = n_reg + 1'b1;
                end
            end
            irm_pkg::ST_INS_E:
            begin
                state_next = irm_pkg::ST_CP_RD;
                hi_next    = 1'b1;
                wdata      = {e_reg, ve_reg};
                if (ve_reg != v_reg)
                begin
                    we     = (n_reg < NW'(MAX_ENTRIES));
                    n_next = n_reg + 1'b1;
                end
            end
            irm_pkg::ST_FINISH:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = irm_pkg::ST_IDLE;
                    if (type_reg == irm_pkg::REQ_LOOKUP)
                    begin
                        found_next = ve_reg;
                    end
                    else if (hi_reg)
                    begin
                        if (n_reg > NW'(MAX_ENTRIES))
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            count_next   = CW'(n_reg);
                            cnt_out_next = CW'(n_reg);
                            bank_next    = !bank_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = irm_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign found_value = found_reg;
    assign entry_count = OW'(cnt_out_reg);
    assign status      = status_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (found_reg == '0))
        else $error("rejected assign carries a value");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> $past(out_load))
        else $error("bank switched outside result load");
endmodule
`default_nettype wire

[bench/interval_range_map_table_checker.sv]
// Checker for interval_range_map_table: watches request, result and config channels,
// keeps its own interval map, and counts mismatches. Depends on irm_pkg.
`timescale 1ns / 1ps
module interval_range_map_table_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] range_begin,
    input  wire logic [15:0] range_end,
    input  wire logic [7:0]  new_value,
    input  wire logic [15:0] probe_key,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  found_value,
    input  wire logic [6:0]  entry_count,
    input  wire logic        status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending,
    output int               beats_in,
    output int               beats_out,
    output int               rejects
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic [7:0] found;
        logic [6:0] count;
        logic       rejected;
    } map_result_t;

    logic [15:0] map_keys [DEPTH];
    logic [7:0]  map_vals [DEPTH];
    int          map_count;
    logic [7:0]  map_default;
    map_result_t result_q[$];

    // keys held with sign bit flipped so unsigned compare is signed order
    function automatic logic [7:0] value_for(logic [15:0] k);
        logic [7:0] v;
        v = map_default;
        for (int i = 0; i < map_count; i++)
        begin
            if (map_keys[i] <= k) v = map_vals[i];
            else break;
        end
        return v;
    endfunction

    function automatic logic apply_assign(logic [15:0] b, logic [15:0] e, logic [7:0] v);
        logic [15:0] nk [DEPTH+2];
        logic [7:0]  nv [DEPTH+2];
        logic [7:0]  v_end;
        logic [7:0]  v_prev;
        int          i;
        int          n;
        i = 0;
        n = 0;
        if (!(b < e)) return 1'b1;
        v_end = value_for(e);
        while (i < map_count && map_keys[i] < b)
        begin
            nk[n] = map_keys[i]; nv[n] = map_vals[i]; n++; i++;
        end
        v_prev = (n > 0) ? nv[n-1] : map_default;
        if (v != v_prev)
        begin
            nk[n] = b; nv[n] = v; n++;
        end
        if (v_end != v)
        begin
            nk[n] = e; nv[n] = v_end; n++;
        end
        while (i < map_count && map_keys[i] <= e) i++;
        while (i < map_count)
        begin
            nk[n] = map_keys[i]; nv[n] = map_vals[i]; n++; i++;
        end
        if (n > DEPTH) return 1'b0;
        for (int j = 0; j < n; j++)
        begin
            map_keys[j] = nk[j];
            map_vals[j] = nv[j];
        end
        map_count = n;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_result_t r;
        map_result_t x;
        if (!rst_n)
        begin
            map_count   = 0;
            map_default = '0;
            result_q.delete();
            fail_count  = 0;
            beats_in    = 0;
            beats_out   = 0;
            rejects     = 0;
            pending     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == irm_pkg::ADDR_DEFAULT_VALUE)
                map_default = pwdata[7:0];
            if (in_valid && !in_stall)
            begin
                r = '0;
                if (req_type == irm_pkg::REQ_LOOKUP)
                    r.found = value_for(probe_key ^ 16'h8000);
                else
                    r.rejected = !apply_assign(range_begin ^ 16'h8000,
                                               range_end ^ 16'h8000, new_value);
                if (r.rejected) rejects++;
                r.count = map_count[6:0];
                result_q.push_back(r);
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (result_q.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    x = result_q.pop_front();
                    if (found_value !== x.found)
                    begin
                        $error("found_value: expected %0d got %0d", x.found, found_value);
                        fail_count++;
                    end
                    if (entry_count !== x.count)
                    begin
                        $error("entry_count: expected %0d got %0d", x.count, entry_count);
                        fail_count++;
                    end
                    if (status !== x.rejected)
                    begin
                        $error("status: expected %0d got %0d", x.rejected, status);
                        fail_count++;
                    end
                end
            end
            pending = result_q.size();
        end
    end
endmodule

[bench/interval_range_map_table_tb.sv]
// Top of the interval_range_map_table bench: clock, reset, stimulus and verdict.
// Depends on irm_pkg, the block and interval_range_map_table_checker.
`timescale 1ns / 1ps
module interval_range_map_table_tb;
    // bound on cycles with no beat; long enough for a full-table assign
    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [15:0] range_begin = '0;
    logic [15:0] range_end = '0;
    logic [7:0]  new_value = '0;
    logic [15:0] probe_key = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  found_value;
    logic [6:0]  entry_count;
    logic        status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int beats_in;
    int beats_out;
    int rejects;
    int rd_fail = 0;      // register read-back mismatches
    int idle_cycles = 0;
    bit hold_off = 1'b0;  // long receiver stall window
    int key_span = 64;    // narrow spans make keys collide and the table fill

    always #1 clk = ~clk;

    interval_range_map_table i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .range_begin(range_begin), .range_end(range_end),
        .new_value(new_value), .probe_key(probe_key),
        .out_valid(out_valid), .out_stall(out_stall),
        .found_value(found_value), .entry_count(entry_count), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    interval_range_map_table_checker i_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .range_begin(range_begin), .range_end(range_end), .new_value(new_value),
        .probe_key(probe_key), .out_valid(out_valid), .out_stall(out_stall),
        .found_value(found_value), .entry_count(entry_count), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
        .beats_in(beats_in), .beats_out(beats_out), .rejects(rejects)
    );

    // receiver: stalls on its own random pattern, quiet stretches included
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off) out_stall <= 1'b1;
            else
            begin
                if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("interval_range_map_table test failed");
            $finish;
        end
    end

    // one beat; the caller's payload is held until accepted
    task automatic send_beat(logic t, logic [15:0] b, logic [15:0] e,
                             logic [7:0] v, logic [15:0] k);
        req_type    <= t;
        range_begin <= b;
        range_end   <= e;
        new_value   <= v;
        probe_key   <= k;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    // write the default, then read it back
    task automatic write_default(logic [7:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= irm_pkg::ADDR_DEFAULT_VALUE;
        pwdata  <= {24'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!pready || prdata !== {24'd0, v})
        begin
            $error("prdata: expected %0d got %0d", v, prdata);
            rd_fail++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // let every expected beat drain, then cover the assign latency tail
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    function automatic logic [15:0] near_key();
        return 16'($signed($urandom_range(0, 2 * key_span)) - key_span);
    endfunction

    task automatic random_beat();
        logic [15:0] b;
        logic [15:0] e;
        int          sel;
        sel = $urandom_range(0, 99);
        b = near_key();
        e = b + 16'($urandom_range(1, 12));
        if (sel < 40)
            send_beat(irm_pkg::REQ_LOOKUP, 16'($urandom), 16'($urandom), 8'($urandom),
                      near_key());
        else if (sel < 48)
            send_beat(irm_pkg::REQ_LOOKUP, 16'($urandom), 16'($urandom), 8'($urandom),
                      16'($urandom));
        else if (sel < 88)
            send_beat(irm_pkg::REQ_ASSIGN, b, e, 8'($urandom_range(0, 5)), 16'($urandom));
        else if (sel < 94)
            send_beat(irm_pkg::REQ_ASSIGN, 16'($urandom), 16'($urandom), 8'($urandom),
                      16'($urandom));
        else  // empty or reversed range
            send_beat(irm_pkg::REQ_ASSIGN, e, b, 8'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [15:0] kmin;
        logic [15:0] kmax;
        kmin = 16'h8000;
        kmax = 16'h7fff;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, empty range, overwrite, full key span
        write_default(8'hff);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, kmin);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, kmax);
        send_beat(irm_pkg::REQ_ASSIGN, 16'd5, 16'd5, 8'h12, 16'd0);
        send_beat(irm_pkg::REQ_ASSIGN, 16'd9, 16'd3, 8'h12, 16'd0);
        send_beat(irm_pkg::REQ_ASSIGN, kmin, kmax, 8'h00, 16'hffff);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, kmin);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, kmax);
        send_beat(irm_pkg::REQ_ASSIGN, -16'sd10, 16'd10, 8'hff, 16'd0);
        send_beat(irm_pkg::REQ_ASSIGN, -16'sd5, 16'd5, 8'haa, 16'd0);
        send_beat(irm_pkg::REQ_ASSIGN, -16'sd5, 16'd5, 8'haa, 16'd0);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, -16'sd5);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, 16'd5);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, 16'd4);
        send_beat(irm_pkg::REQ_ASSIGN, 16'd0, kmax, 8'h55, 16'd0);
        send_beat(irm_pkg::REQ_ASSIGN, kmin, 16'd0, 8'hff, 16'd0);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, 16'hffff);
        drain();

        // default changed under a stored table
        write_default(8'h00);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, kmin);
        send_beat(irm_pkg::REQ_ASSIGN, kmin, kmax, 8'h00, 16'd0);

        // fill toward overflow: alternating single-key ranges
        for (int i = 0; i < 70; i++)
            send_beat(irm_pkg::REQ_ASSIGN, 16'(2 * i), 16'(2 * i + 1), 8'(1 + i % 2), 16'd0);
        send_beat(irm_pkg::REQ_LOOKUP, 16'd0, 16'd0, 8'd0, 16'd4);
        drain();

        // random phases across default settings and key spans
        for (int phase = 0; phase < 6; phase++)
        begin
            write_default(phase == 5 ? 8'hff : 8'($urandom_range(0, 5)));
            key_span = (phase % 2) ? 40 : 2000;
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(0, 9) == 0) pause_sender();
                random_beat();
                if (phase == 2 && n == 20)
                begin
                    // receiver holds off while the sender keeps offering beats
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (400) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
            end
            drain();
        end

        $display("covered %0d requests, %0d results, %0d overflow rejects",
                 beats_in, beats_out, rejects);
        $display("directed extremes and table fill, six random phases with new defaults, "
                 , "narrow and wide key spans, long receiver hold-off");
        if (fail_count == 0 && pending == 0 && rd_fail == 0)
            $display("interval_range_map_table test passed");
        else
            $display("interval_range_map_table test failed");
        $finish;
    end
endmodule
